/* sv/bap_pkg.sv */
`default_nettype none
package bap_pkg;

  typedef enum logic [3:0] {
    PH_LEN,
    PH_TYPE,
    PH_SKIP,
    PH_UUID_LO,
    PH_UUID_HI,
    PH_INFO,
    PH_OBJ_ID,
    PH_OBJ_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_TEMP,
    KIND_HUM
  } kind_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_BTH   = 3'd1;
  localparam logic [2:0] ST_BAD_HDR  = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_NO_MEAS  = 3'd4;

  localparam logic [7:0]  AD_SVC_DATA16 = 8'h16;
  localparam logic [15:0] BTHOME_UUID   = 16'hFCD2;
  localparam logic [7:0]  OBJ_PACKET_ID = 8'h00;
  localparam logic [7:0]  OBJ_BATTERY   = 8'h01;
  localparam logic [7:0]  OBJ_TEMP      = 8'h02;
  localparam logic [7:0]  OBJ_HUM       = 8'h03;
  localparam logic [7:0]  OBJ_VOLTAGE   = 8'h0C;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  bytes_left;
    logic        verdict_made;
    logic [2:0]  verdict_code;
    logic [7:0]  uuid_low;
    kind_t       obj_kind;
    logic [1:0]  obj_left;
    logic [7:0]  value_low;
    logic [15:0] temp_value;
    logic [15:0] hum_value;
    logic        temp_flag;
    logic        hum_flag;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:        PH_LEN,
    bytes_left:   8'd0,
    verdict_made: 1'b0,
    verdict_code: ST_NO_BTH,
    uuid_low:     8'd0,
    obj_kind:     KIND_SKIP,
    obj_left:     2'd0,
    value_low:    8'd0,
    temp_value:   16'd0,
    hum_value:    16'd0,
    temp_flag:    1'b0,
    hum_flag:     1'b0
  };

  typedef struct packed {
    logic [2:0]  status;
    logic        temp_seen;
    logic [15:0] temp_centi;
    logic        hum_seen;
    logic [15:0] hum_centi;
  } result_t;

endpackage
`default_nettype wire

/* sv/bap_step.sv */
`default_nettype none
module bap_step
  import bap_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] data,
  output state_t     nxt,
  output result_t    res
);

  logic [7:0] left_dec;
  logic       at_end;
  logic [1:0] need;
  kind_t      kind;
  logic       known;
  logic       done;
  logic [2:0] code;

  assign left_dec = cur.bytes_left - 8'd1;
  assign at_end   = (left_dec == 8'd0);

  // object id decode
  always_comb begin
    need  = 2'd2;
    kind  = KIND_SKIP;
    known = 1'b1;
    case (data)
      OBJ_TEMP:      kind = KIND_TEMP;
      OBJ_HUM:       kind = KIND_HUM;
      OBJ_PACKET_ID: need = 2'd1;
      OBJ_BATTERY:   need = 2'd1;
      OBJ_VOLTAGE:   need = 2'd2;
      default:       known = 1'b0;
    endcase
  end

  always_comb begin
    nxt = cur;
    if (cur.phase == PH_LEN) begin
      if (data == 8'd0) begin
        nxt.verdict_made = 1'b1;
        nxt.verdict_code = ST_NO_BTH;
        nxt.phase        = PH_DONE;
      end else begin
        nxt.bytes_left = data;
        nxt.phase      = PH_TYPE;
      end
    end else if (cur.phase != PH_DONE) begin
      nxt.bytes_left = left_dec;
      case (cur.phase)
        PH_TYPE: begin
          if (data == AD_SVC_DATA16 && left_dec >= 8'd2) begin
            nxt.phase = PH_UUID_LO;
          end else begin
            nxt.phase = PH_SKIP;
          end
        end
        PH_UUID_LO: begin
          nxt.uuid_low = data;
          nxt.phase    = PH_UUID_HI;
        end
        PH_UUID_HI: begin
          if ({data, cur.uuid_low} != BTHOME_UUID) begin
            nxt.phase = PH_SKIP;
          end else if (at_end) begin
            nxt.verdict_made = 1'b1;
            nxt.verdict_code = ST_BAD_HDR;
          end else begin
            nxt.phase = PH_INFO;
          end
        end
        PH_INFO: begin
          if (data[0]) begin
            // encrypted payloads are rejected
            nxt.verdict_made = 1'b1;
            nxt.verdict_code = ST_BAD_HDR;
            nxt.phase        = PH_SKIP;
          end else if (at_end) begin
            nxt.verdict_made = 1'b1;
            nxt.verdict_code = (cur.temp_flag || cur.hum_flag) ? ST_OK : ST_NO_MEAS;
          end else begin
            nxt.phase = PH_OBJ_ID;
          end
        end
        PH_OBJ_ID: begin
          if (!known) begin
            nxt.verdict_made = 1'b1;
            nxt.verdict_code = (cur.temp_flag || cur.hum_flag) ? ST_OK : ST_NO_MEAS;
            nxt.phase        = PH_SKIP;
          end else if ({6'd0, need} > left_dec) begin
            nxt.verdict_made = 1'b1;
            nxt.verdict_code = ST_TRUNC;
            nxt.phase        = PH_SKIP;
          end else begin
            nxt.obj_kind = kind;
            nxt.obj_left = need;
            nxt.phase    = PH_OBJ_DATA;
          end
        end
        PH_OBJ_DATA: begin
          if (cur.obj_left == 2'd2) begin
            nxt.value_low = data;
            nxt.obj_left  = 2'd1;
          end else begin
            nxt.obj_left = 2'd0;
            if (cur.obj_kind == KIND_TEMP) begin
              nxt.temp_value = {data, cur.value_low};
              nxt.temp_flag  = 1'b1;
            end else if (cur.obj_kind == KIND_HUM) begin
              nxt.hum_value = {data, cur.value_low};
              nxt.hum_flag  = 1'b1;
            end
            if (at_end) begin
              nxt.verdict_made = 1'b1;
              nxt.verdict_code = (nxt.temp_flag || nxt.hum_flag) ? ST_OK : ST_NO_MEAS;
            end else begin
              nxt.phase = PH_OBJ_ID;
            end
          end
        end
        default: begin
        end
      endcase
      // structure complete
      if (at_end) begin
        nxt.phase = nxt.verdict_made ? PH_DONE : PH_LEN;
      end
    end
  end

  // result as seen if this byte closes the payload
  always_comb begin
    code = (nxt.phase == PH_DONE) ? nxt.verdict_code : ST_NO_BTH;
    done = (nxt.phase == PH_DONE) && (code != ST_NO_BTH) && (code != ST_BAD_HDR);
    res.status     = code;
    res.temp_seen  = done && nxt.temp_flag;
    res.temp_centi = (done && nxt.temp_flag) ? nxt.temp_value : 16'd0;
    res.hum_seen   = done && nxt.hum_flag;
    res.hum_centi  = (done && nxt.hum_flag) ? nxt.hum_value : 16'd0;
  end

endmodule
`default_nettype wire

/* sv/bthome_adv_payload_parser.sv */
// the last byte is held in the input register; its result is then written to the output register
// throughput: one byte per cycle barring the stall below; the parse state updates once per byte in a single pass
// a result waiting in the output register only stalls input when a further last byte arrives
// reset (rst, synchronous, active high) empties input and output registers and
// returns the parser to the expect-structure-length phase
`default_nettype none
module bthome_adv_payload_parser
  import bap_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         payload_byte,
  input  wire logic               last_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic                    temp_seen,
  output logic signed [15:0]      temp_centi,
  output logic                    hum_seen,
  output logic [15:0]             hum_centi
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  // parser state and next value from the step logic
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t res;

  logic proceed;

  // the held byte moves on unless it closes a payload and the result slot is occupied and not being taken
  assign proceed  = in_full && (!in_last || !out_valid || out_ready);
  assign in_ready = !in_full || proceed;

  bap_step u_step (
    .cur  (state),
    .data (in_byte),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte <= payload_byte;
      in_last <= last_byte;
    end
  end

  // parser state; a finished payload returns to the reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (proceed) begin
      state <= in_last ? STATE_RESET : state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && in_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (proceed && in_last) begin
      res <= step_res;
    end
  end

  assign status     = res.status;
  assign temp_seen  = res.temp_seen;
  assign temp_centi = $signed(res.temp_centi);
  assign hum_seen   = res.hum_seen;
  assign hum_centi  = res.hum_centi;

endmodule
`default_nettype wire
